FILE: hw/rtl/dosc_pkg.sv
// types and codes for the display owner and session controller
// no dependencies; imported by display_owner_session_controller
`default_nettype none

package dosc_pkg;

  // request kinds
  localparam logic [3:0] KIND_ACQUIRE        = 4'd0;
  localparam logic [3:0] KIND_RELEASE        = 4'd1;
  localparam logic [3:0] KIND_BEGIN          = 4'd2;
  localparam logic [3:0] KIND_COMMIT         = 4'd3;
  localparam logic [3:0] KIND_ABORT          = 4'd4;
  localparam logic [3:0] KIND_BEGIN_RELEASE  = 4'd5;
  localparam logic [3:0] KIND_RECOVERY       = 4'd6;
  localparam logic [3:0] KIND_FINISH_RESTORE = 4'd7;
  localparam logic [3:0] KIND_PRESENT_CHECK  = 4'd8;

  // owner codes
  localparam logic [1:0] OWN_NONE = 2'd0;
  localparam logic [1:0] OWN_TERM = 2'd1;
  localparam logic [1:0] OWN_FB   = 2'd2;

  // session modes
  localparam logic [2:0] MODE_CONSOLE   = 3'd0;
  localparam logic [2:0] MODE_ACQUIRING = 3'd1;
  localparam logic [2:0] MODE_GUI       = 3'd2;
  localparam logic [2:0] MODE_RESTORING = 3'd3;
  localparam logic [2:0] MODE_FALLBACK  = 3'd4;

  typedef struct packed {
    logic [3:0]  kind;
    logic [1:0]  owner;
    logic        token_held;
    logic [31:0] win_proc_id;
    logic [31:0] window_gen;
    logic [31:0] disp_proc_id;
    logic [31:0] display_gen;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic [31:0] generation;
    logic [31:0] process_id;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [1:0]  lock_holder;
    logic [7:0]  nest_depth;
    logic [2:0]  session_mode;
    logic [31:0] live_gen;
    logic        gui_active;
    logic        terminal_allowed;
    logic [31:0] acquire_total;
    logic [31:0] busy_total;
    logic [15:0] active_width;
    logic [15:0] active_height;
  } rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/display_owner_session_controller.sv
// display owner and session controller: nested ownership lock plus session modes
// depends on dosc_pkg (request and response structs, owner/mode/kind codes)
//
// usage: requests arrive on req (req_valid/req_ready), one response per request
// leaves on rsp (rsp_valid/rsp_ready). the request is decoded against the
// current state in the cycle it is accepted; state updates at that edge and
// the response, showing the state after the request, sits in the output
// register from the next cycle on. throughput is one item per cycle while
// rsp_ready is high: the output register drains and refills in the same cycle.
// if the receiver stalls, the response holds and req_ready stays low until
// it is taken, so nothing is lost or overtaken.
// reset: no owner, depth zero, counters zero, console mode, generation zero,
// stored ids and size zero, no response pending.
// MAX_NEST bounds the nesting depth; COUNT_BITS sets the width of the
// wrapping acquire and busy counters (low 32 bits are reported).
`default_nettype none

module display_owner_session_controller
  import dosc_pkg::*;
#(
  parameter int MAX_NEST   = 255,
  parameter int COUNT_BITS = 32
) (
  input  wire       clk,
  input  wire       rst,
  input  wire       req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire       rsp_ready,
  output rsp_t      rsp
);

  localparam int DW = $clog2(MAX_NEST + 1);

  logic [1:0]            owner;
  logic [DW-1:0]         depth;
  logic [COUNT_BITS-1:0] acquire_cnt;
  logic [COUNT_BITS-1:0] busy_cnt;
  logic [2:0]            mode;
  logic [31:0]           gen;
  logic [31:0]           win_pid;
  logic [31:0]           win_gen;
  logic [31:0]           disp_pid;
  logic [31:0]           disp_gen;
  logic [15:0]           width;
  logic [15:0]           height;

  logic [1:0]            owner_next;
  logic [DW-1:0]         depth_next;
  logic [COUNT_BITS-1:0] acquire_cnt_next;
  logic [COUNT_BITS-1:0] busy_cnt_next;
  logic [2:0]            mode_next;
  logic [31:0]           gen_next;
  logic [31:0]           win_pid_next;
  logic [31:0]           win_gen_next;
  logic [31:0]           disp_pid_next;
  logic [31:0]           disp_gen_next;
  logic [15:0]           width_next;
  logic [15:0]           height_next;
  logic                  ok;
  rsp_t                  rsp_next;

  logic                  accept;
  logic                  owner_valid;
  logic                  mode_ok;
  logic                  at_max;
  logic [31:0]           gen_inc;
  logic [DW+7:0]         depth_ext;
  logic [COUNT_BITS+31:0] acq_ext;
  logic [COUNT_BITS+31:0] busy_ext;

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;

  assign owner_valid = (req.owner == OWN_TERM) || (req.owner == OWN_FB);
  assign mode_ok = (req.owner == OWN_TERM) ?
      (mode == MODE_CONSOLE || mode == MODE_RESTORING || mode == MODE_FALLBACK) :
      (mode == MODE_CONSOLE || mode == MODE_GUI || mode == MODE_FALLBACK);
  assign at_max  = depth >= DW'(MAX_NEST);
  // generation skips zero on wrap
  assign gen_inc = (gen == 32'hFFFF_FFFF) ? 32'd1 : gen + 32'd1;

  always_comb begin
    owner_next       = owner;
    depth_next       = depth;
    acquire_cnt_next = acquire_cnt;
    busy_cnt_next    = busy_cnt;
    mode_next        = mode;
    gen_next         = gen;
    win_pid_next     = win_pid;
    win_gen_next     = win_gen;
    disp_pid_next    = disp_pid;
    disp_gen_next    = disp_gen;
    width_next       = width;
    height_next      = height;
    ok               = 1'b0;
    case (req.kind)
      KIND_ACQUIRE: begin
        if (owner_valid) begin
          if (!mode_ok || (owner != OWN_NONE && owner != req.owner) || at_max) begin
            busy_cnt_next = busy_cnt + 1'b1;
          end else begin
            owner_next       = req.owner;
            depth_next       = depth + 1'b1;
            acquire_cnt_next = acquire_cnt + 1'b1;
            ok               = 1'b1;
          end
        end
      end
      KIND_RELEASE: begin
        if (req.token_held && owner == req.owner && depth != '0) begin
          depth_next = depth - 1'b1;
          if (depth == DW'(1)) begin
            owner_next = OWN_NONE;
          end
          ok = 1'b1;
        end
      end
      KIND_BEGIN: begin
        if (req.win_proc_id != '0 && req.window_gen != '0 && req.disp_proc_id != '0 &&
            req.display_gen != '0 && req.frame_width != '0 && req.frame_height != '0 &&
            (mode == MODE_CONSOLE || mode == MODE_FALLBACK) && owner == OWN_NONE) begin
          gen_next      = gen_inc;
          win_pid_next  = req.win_proc_id;
          win_gen_next  = req.window_gen;
          disp_pid_next = req.disp_proc_id;
          disp_gen_next = req.display_gen;
          width_next    = req.frame_width;
          height_next   = req.frame_height;
          mode_next     = MODE_ACQUIRING;
          ok            = 1'b1;
        end
      end
      KIND_COMMIT: begin
        if (mode == MODE_ACQUIRING && req.generation != '0 && req.generation == gen) begin
          mode_next = MODE_GUI;
          ok        = 1'b1;
        end
      end
      KIND_ABORT: begin
        if (mode == MODE_ACQUIRING && req.generation == gen) begin
          mode_next     = MODE_FALLBACK;
          win_pid_next  = '0;
          win_gen_next  = '0;
          disp_pid_next = '0;
          disp_gen_next = '0;
          width_next    = '0;
          height_next   = '0;
          ok            = 1'b1;
        end
      end
      KIND_BEGIN_RELEASE: begin
        if (mode == MODE_GUI && req.generation != '0 && req.generation == gen &&
            req.win_proc_id == win_pid && req.window_gen == win_gen) begin
          mode_next = MODE_RESTORING;
          ok        = 1'b1;
        end
      end
      KIND_RECOVERY: begin
        if (req.process_id != '0 && req.generation != '0 &&
            ((req.process_id == win_pid && req.generation == win_gen) ||
             (req.process_id == disp_pid && req.generation == disp_gen)) &&
            (mode == MODE_ACQUIRING || mode == MODE_GUI)) begin
          mode_next = MODE_RESTORING;
          ok        = 1'b1;
        end
      end
      KIND_FINISH_RESTORE: begin
        if (mode == MODE_RESTORING || mode == MODE_FALLBACK) begin
          mode_next     = MODE_CONSOLE;
          win_pid_next  = '0;
          win_gen_next  = '0;
          disp_pid_next = '0;
          disp_gen_next = '0;
          width_next    = '0;
          height_next   = '0;
          ok            = 1'b1;
        end
      end
      KIND_PRESENT_CHECK: begin
        ok = mode == MODE_GUI && req.disp_proc_id != '0 && req.disp_proc_id == disp_pid &&
             req.display_gen != '0 && req.display_gen == disp_gen;
      end
      default: begin
      end
    endcase
  end

  // zero-extend before taking the reported low bits, whatever the widths
  assign depth_ext = {8'd0, depth_next};
  assign acq_ext   = {32'd0, acquire_cnt_next};
  assign busy_ext  = {32'd0, busy_cnt_next};

  always_comb begin
    rsp_next.ok                 = ok;
    rsp_next.lock_holder        = owner_next;
    rsp_next.nest_depth         = depth_ext[7:0];
    rsp_next.session_mode       = mode_next;
    rsp_next.live_gen           = gen_next;
    rsp_next.gui_active         = mode_next == MODE_GUI;
    rsp_next.terminal_allowed   = mode_next == MODE_CONSOLE ||
                                  mode_next == MODE_RESTORING ||
                                  mode_next == MODE_FALLBACK;
    rsp_next.acquire_total      = acq_ext[31:0];
    rsp_next.busy_total         = busy_ext[31:0];
    rsp_next.active_width       = width_next;
    rsp_next.active_height      = height_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owner       <= OWN_NONE;
      depth       <= '0;
      acquire_cnt <= '0;
      busy_cnt    <= '0;
      mode        <= MODE_CONSOLE;
      gen         <= '0;
      win_pid     <= '0;
      win_gen     <= '0;
      disp_pid    <= '0;
      disp_gen    <= '0;
      width       <= '0;
      height      <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (accept) begin
        owner       <= owner_next;
        depth       <= depth_next;
        acquire_cnt <= acquire_cnt_next;
        busy_cnt    <= busy_cnt_next;
        mode        <= mode_next;
        gen         <= gen_next;
        win_pid     <= win_pid_next;
        win_gen     <= win_gen_next;
        disp_pid    <= disp_pid_next;
        disp_gen    <= disp_gen_next;
        width       <= width_next;
        height      <= height_next;
        rsp_valid   <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  a_owner_depth : assert property (@(posedge clk) disable iff (rst)
    (owner == OWN_NONE) == (depth == '0))
    else $error("owner and nesting depth disagree");

  a_depth_bound : assert property (@(posedge clk) disable iff (rst)
    depth <= DW'(MAX_NEST))
    else $error("nesting depth beyond bound");

  a_rsp_follows : assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid)
    else $error("accepted item left no response");

  a_gen_live : assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_ACQUIRING || mode == MODE_GUI) |-> gen != '0)
    else $error("active session with zero generation");

  a_counts_step : assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(acquire_cnt) && $stable(busy_cnt))
    else $error("counter moved without an item");

endmodule

`default_nettype wire
